[rtl/core/ufur_pkg.sv]
package ufur_pkg;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
        logic       flash_ok;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  byte_value;
        logic [31:0] offset;
        logic [31:0] image_size;
        logic [31:0] image_crc;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_ERASE,
        PH_PAYLOAD,
        PH_PKTCRC,
        PH_PROGRAM,
        PH_END
    } phase_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_PROG,
        BS_TAIL
    } back_state_t;

    localparam logic [1:0] FUNC_BYTE     = 2'd0;
    localparam logic [1:0] FUNC_TICK     = 2'd1;
    localparam logic [1:0] FUNC_FLASH    = 2'd2;
    localparam logic [1:0] FUNC_RESERVED = 2'd3;

    localparam logic [2:0] K_SEND  = 3'd0;
    localparam logic [2:0] K_ERASE = 3'd1;
    localparam logic [2:0] K_PROG  = 3'd2;
    localparam logic [2:0] K_NOUPD = 3'd3;
    localparam logic [2:0] K_DONE  = 3'd4;
    localparam logic [2:0] K_FAIL  = 3'd5;

    localparam logic [2:0] REG_MAGIC_WORD    = 3'd0;
    localparam logic [2:0] REG_MAGIC_LENGTH  = 3'd1;
    localparam logic [2:0] REG_WINDOW_MS     = 3'd2;
    localparam logic [2:0] REG_SLOT_CAPACITY = 3'd3;
    localparam logic [2:0] REG_MAX_RETRIES   = 3'd4;
    localparam logic [2:0] REG_ACK_CODE      = 3'd5;
    localparam logic [2:0] REG_NAK_CODE      = 3'd6;

    localparam logic [11:0] HEADER_TIMEOUT = 12'd3000;
    localparam logic [11:0] PACKET_TIMEOUT = 12'd2000;

    // Up to three immediate results plus a flag asking the back part to
    // stream the buffered packet before them.
    typedef struct packed {
        logic        prog;
        logic [1:0]  count;
        logic [2:0]  kind0;
        logic [7:0]  byte0;
        logic [2:0]  kind1;
        logic [7:0]  byte1;
        logic [2:0]  kind2;
        logic [31:0] size2;
        logic [31:0] crc2;
    } cmd_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/core/ufur_front.sv]
module ufur_front #(
    parameter int PAYLOAD_MAX = 32,
    parameter int PW = $clog2(PAYLOAD_MAX + 1),
    parameter int AW = $clog2(PAYLOAD_MAX)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  ufur_pkg::in_item_t   in_item,
    input  logic                 cfg_valid,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    output logic [7:0]           ack_code,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output ufur_pkg::cmd_t       cmd,
    output logic                 buf_we,
    output logic [AW-1:0]        buf_addr,
    output logic [7:0]           buf_data,
    output logic [PW-1:0]        pkt_len,
    output logic [31:0]          base_off
);
    logic [63:0] magic_word_reg;
    logic [3:0]  magic_length_reg;
    logic [31:0] window_ms_reg, slot_capacity_reg;
    logic [7:0]  max_retries_reg, ack_code_reg, nak_code_reg;

    ufur_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  match_reg, match_next;
    logic [31:0] window_reg, window_next;
    logic [11:0] idle_reg, idle_next;
    logic [31:0] shift_reg, shift_next;
    logic [3:0]  fcount_reg, fcount_next;
    logic [31:0] length_reg, length_next, expect_reg, expect_next;
    logic [31:0] accepted_reg, accepted_next;
    logic [PW-1:0] plen_reg, plen_next, got_reg, got_next;
    logic [7:0]  attempt_reg, attempt_next;
    logic [31:0] pcrc_reg, pcrc_next, icrc_c_reg, icrc_c_next, icrc_t_reg, icrc_t_next;

    ufur_pkg::cmd_t c;
    logic take;

    assign full      = !cmd_ready;
    assign take      = push && cmd_ready;
    assign ack_code  = ack_code_reg;
    assign pkt_len   = plen_reg;
    assign base_off  = accepted_reg;
    assign cmd       = c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg    <= '0;
            magic_length_reg  <= 4'd8;
            window_ms_reg     <= 32'd5000;
            slot_capacity_reg <= 32'd131072;
            max_retries_reg   <= 8'd3;
            ack_code_reg      <= 8'd6;
            nak_code_reg      <= 8'd21;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ufur_pkg::REG_MAGIC_WORD:    magic_word_reg    <= cfg_data;
                ufur_pkg::REG_MAGIC_LENGTH:  magic_length_reg  <= cfg_data[3:0];
                ufur_pkg::REG_WINDOW_MS:     window_ms_reg     <= cfg_data[31:0];
                ufur_pkg::REG_SLOT_CAPACITY: slot_capacity_reg <= cfg_data[31:0];
                ufur_pkg::REG_MAX_RETRIES:   max_retries_reg   <= cfg_data[7:0];
                ufur_pkg::REG_ACK_CODE:      ack_code_reg      <= cfg_data[7:0];
                ufur_pkg::REG_NAK_CODE:      nak_code_reg      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ufur_pkg::PH_HUNT;
            match_reg    <= '0;
            window_reg   <= '0;
            idle_reg     <= '0;
            shift_reg    <= '0;
            fcount_reg   <= '0;
            length_reg   <= '0;
            expect_reg   <= '0;
            accepted_reg <= '0;
            plen_reg     <= '0;
            got_reg      <= '0;
            attempt_reg  <= '0;
            pcrc_reg     <= '1;
            icrc_c_reg   <= '1;
            icrc_t_reg   <= '1;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            match_reg    <= match_next;
            window_reg   <= window_next;
            idle_reg     <= idle_next;
            shift_reg    <= shift_next;
            fcount_reg   <= fcount_next;
            length_reg   <= length_next;
            expect_reg   <= expect_next;
            accepted_reg <= accepted_next;
            plen_reg     <= plen_next;
            got_reg      <= got_next;
            attempt_reg  <= attempt_next;
            pcrc_reg     <= pcrc_next;
            icrc_c_reg   <= icrc_c_next;
            icrc_t_reg   <= icrc_t_next;
        end
    end

    always_comb
    begin
        logic [3:0]  len;
        logic [7:0]  want;
        logic [7:0]  lim;
        logic [31:0] sh;
        logic [31:0] rem;
        logic [31:0] acc;
        logic [7:0]  att;
        logic        newpkt, newatt;
        logic [7:0]  b;

        phase_next    = phase_reg;
        match_next    = match_reg;
        window_next   = window_reg;
        idle_next     = idle_reg;
        shift_next    = shift_reg;
        fcount_next   = fcount_reg;
        length_next   = length_reg;
        expect_next   = expect_reg;
        accepted_next = accepted_reg;
        plen_next     = plen_reg;
        got_next      = got_reg;
        attempt_next  = attempt_reg;
        pcrc_next     = pcrc_reg;
        icrc_c_next   = icrc_c_reg;
        icrc_t_next   = icrc_t_reg;
        c             = '0;
        buf_we        = 1'b0;
        buf_addr      = got_reg[AW-1:0];
        b             = in_item.rx_byte;
        buf_data      = b;
        newpkt        = 1'b0;
        newatt        = 1'b0;
        rem           = '0;
        len  = (magic_length_reg == 4'd0) ? 4'd1 :
               ((magic_length_reg > 4'd8) ? 4'd8 : magic_length_reg);
        want = magic_word_reg[{match_reg[2:0], 3'b000} +: 8];
        lim  = (max_retries_reg == 8'd0) ? 8'd1 : max_retries_reg;
        sh   = {b, shift_reg[31:8]};
        att  = attempt_reg + 8'd1;
        acc  = accepted_reg;

        case (phase_reg)
            ufur_pkg::PH_HUNT:
            begin
                if (in_item.func == ufur_pkg::FUNC_TICK)
                begin
                    if (window_reg != '1)
                        window_next = window_reg + 32'd1;
                    if (window_next >= window_ms_reg)
                    begin
                        phase_next = ufur_pkg::PH_END;
                        c.count = 2'd1;
                        c.kind0 = ufur_pkg::K_NOUPD;
                    end
                end
                else if (in_item.func == ufur_pkg::FUNC_BYTE)
                begin
                    if (window_reg >= window_ms_reg)
                    begin
                        phase_next = ufur_pkg::PH_END;
                        c.count = 2'd1;
                        c.kind0 = ufur_pkg::K_NOUPD;
                    end
                    else if (b == want)
                    begin
                        match_next = match_reg + 4'd1;
                        if (match_next >= len)
                        begin
                            c.count = 2'd1;
                            c.kind0 = ufur_pkg::K_SEND;
                            c.byte0 = ack_code_reg;
                            phase_next  = ufur_pkg::PH_HEADER;
                            shift_next  = '0;
                            fcount_next = '0;
                            idle_next   = '0;
                        end
                    end
                    else
                    begin
                        match_next = (b == magic_word_reg[7:0]) ? 4'd1 : 4'd0;
                    end
                end
            end
            ufur_pkg::PH_HEADER:
            begin
                if (in_item.func == ufur_pkg::FUNC_TICK)
                begin
                    if (idle_reg != '1)
                        idle_next = idle_reg + 12'd1;
                    if (idle_next >= ufur_pkg::HEADER_TIMEOUT)
                    begin
                        phase_next = ufur_pkg::PH_END;
                        c.count = 2'd2;
                        c.kind0 = ufur_pkg::K_SEND;
                        c.byte0 = nak_code_reg;
                        c.kind1 = ufur_pkg::K_FAIL;
                    end
                end
                else if (in_item.func == ufur_pkg::FUNC_BYTE)
                begin
                    shift_next  = sh;
                    fcount_next = fcount_reg + 4'd1;
                    idle_next   = '0;
                    if (fcount_next == 4'd4)
                        length_next = sh;
                    else if (fcount_next == 4'd8)
                        expect_next = sh;
                    else if (fcount_next >= 4'd12)
                    begin
                        fcount_next = '0;
                        c.count = 2'd2;
                        if (length_reg == '0 || length_reg > slot_capacity_reg)
                        begin
                            phase_next = ufur_pkg::PH_END;
                            c.kind0 = ufur_pkg::K_SEND;
                            c.byte0 = nak_code_reg;
                            c.kind1 = ufur_pkg::K_FAIL;
                        end
                        else
                        begin
                            phase_next = ufur_pkg::PH_ERASE;
                            c.kind0 = ufur_pkg::K_SEND;
                            c.byte0 = ack_code_reg;
                            c.kind1 = ufur_pkg::K_ERASE;
                        end
                    end
                end
            end
            ufur_pkg::PH_ERASE:
            begin
                if (in_item.func == ufur_pkg::FUNC_FLASH)
                begin
                    if (!in_item.flash_ok)
                    begin
                        phase_next = ufur_pkg::PH_END;
                        c.count = 2'd2;
                        c.kind0 = ufur_pkg::K_SEND;
                        c.byte0 = nak_code_reg;
                        c.kind1 = ufur_pkg::K_FAIL;
                    end
                    else
                    begin
                        accepted_next = '0;
                        acc           = '0;
                        icrc_c_next   = '1;
                        newpkt        = 1'b1;
                    end
                end
            end
            ufur_pkg::PH_PAYLOAD, ufur_pkg::PH_PKTCRC:
            begin
                if (in_item.func == ufur_pkg::FUNC_TICK)
                begin
                    if (idle_reg != '1)
                        idle_next = idle_reg + 12'd1;
                    if (idle_next >= ufur_pkg::PACKET_TIMEOUT)
                    begin
                        attempt_next = att;
                        c.kind0 = ufur_pkg::K_SEND;
                        c.byte0 = nak_code_reg;
                        if (att >= lim)
                        begin
                            phase_next = ufur_pkg::PH_END;
                            c.count = 2'd2;
                            c.kind1 = ufur_pkg::K_FAIL;
                        end
                        else
                        begin
                            c.count = 2'd1;
                            newatt  = 1'b1;
                        end
                    end
                end
                else if (in_item.func == ufur_pkg::FUNC_BYTE &&
                         phase_reg == ufur_pkg::PH_PAYLOAD)
                begin
                    idle_next = '0;
                    if (got_reg < plen_reg)
                    begin
                        buf_we      = 1'b1;
                        pcrc_next   = ufur_pkg::crc_byte(pcrc_reg, b);
                        icrc_t_next = ufur_pkg::crc_byte(icrc_t_reg, b);
                        got_next    = got_reg + 1'b1;
                    end
                    if (got_next >= plen_reg)
                    begin
                        phase_next  = ufur_pkg::PH_PKTCRC;
                        shift_next  = '0;
                        fcount_next = '0;
                    end
                end
                else if (in_item.func == ufur_pkg::FUNC_BYTE)
                begin
                    shift_next  = sh;
                    fcount_next = fcount_reg + 4'd1;
                    idle_next   = '0;
                    if (fcount_next >= 4'd4)
                    begin
                        fcount_next = '0;
                        if (~pcrc_reg == sh)
                        begin
                            phase_next = ufur_pkg::PH_PROGRAM;
                            c.prog = 1'b1;
                        end
                        else
                        begin
                            attempt_next = att;
                            c.kind0 = ufur_pkg::K_SEND;
                            c.byte0 = nak_code_reg;
                            if (att >= lim)
                            begin
                                phase_next = ufur_pkg::PH_END;
                                c.count = 2'd2;
                                c.kind1 = ufur_pkg::K_FAIL;
                            end
                            else
                            begin
                                c.count = 2'd1;
                                newatt  = 1'b1;
                            end
                        end
                    end
                end
            end
            ufur_pkg::PH_PROGRAM:
            begin
                if (in_item.func == ufur_pkg::FUNC_FLASH)
                begin
                    if (!in_item.flash_ok)
                    begin
                        phase_next = ufur_pkg::PH_END;
                        c.count = 2'd2;
                        c.kind0 = ufur_pkg::K_SEND;
                        c.byte0 = nak_code_reg;
                        c.kind1 = ufur_pkg::K_FAIL;
                    end
                    else
                    begin
                        icrc_c_next   = icrc_t_reg;
                        acc           = accepted_reg + 32'(plen_reg);
                        accepted_next = acc;
                        c.kind0 = ufur_pkg::K_SEND;
                        c.byte0 = ack_code_reg;
                        if (acc >= length_reg)
                        begin
                            phase_next = ufur_pkg::PH_END;
                            c.count = 2'd3;
                            c.kind1 = ufur_pkg::K_SEND;
                            if (~icrc_t_reg != expect_reg)
                            begin
                                c.byte1 = nak_code_reg;
                                c.kind2 = ufur_pkg::K_FAIL;
                            end
                            else
                            begin
                                c.byte1 = ack_code_reg;
                                c.kind2 = ufur_pkg::K_DONE;
                                c.size2 = length_reg;
                                c.crc2  = ~icrc_t_reg;
                            end
                        end
                        else
                        begin
                            c.count = 2'd1;
                            newpkt  = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (newpkt)
        begin
            rem = length_reg - acc;
            plen_next = (rem > 32'(PAYLOAD_MAX)) ? PW'(PAYLOAD_MAX) : rem[PW-1:0];
            attempt_next = '0;
            newatt = 1'b1;
        end
        if (newatt)
        begin
            got_next    = '0;
            idle_next   = '0;
            pcrc_next   = '1;
            icrc_t_next = (phase_reg == ufur_pkg::PH_PROGRAM) ? icrc_t_reg :
                          icrc_c_next;
            shift_next  = '0;
            fcount_next = '0;
            phase_next  = ufur_pkg::PH_PAYLOAD;
        end
        buf_we    = buf_we && take;
        cmd_valid = take && (c.prog || c.count != 2'd0);
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        got_reg <= plen_reg) else $error("packet count beyond length");
    assert property (@(posedge clk) disable iff (!rst_n)
        plen_reg <= PW'(PAYLOAD_MAX)) else $error("packet length too large");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> cmd_ready) else $error("command issued while queue full");
endmodule

[rtl/core/ufur_back.sv]
module ufur_back #(
    parameter int PAYLOAD_MAX = 32,
    parameter int PW = $clog2(PAYLOAD_MAX + 1),
    parameter int AW = $clog2(PAYLOAD_MAX)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  ufur_pkg::cmd_t       cmd,
    input  logic                 buf_we,
    input  logic [AW-1:0]        buf_addr,
    input  logic [7:0]           buf_data,
    input  logic [PW-1:0]        pkt_len,
    input  logic [31:0]          base_off,
    output logic                 empty,
    input  logic                 pop,
    output ufur_pkg::out_item_t  result
);
    logic [7:0] mem [PAYLOAD_MAX];
    logic [7:0] rd_reg;

    ufur_pkg::back_state_t st_reg, st_next;
    ufur_pkg::cmd_t cmd_reg;
    logic [PW-1:0] idx_reg, idx_next;
    logic [1:0]    tail_reg, tail_next;
    logic          ov_reg;
    ufur_pkg::out_item_t ob_reg, item;
    logic          emit, adv, slot_free;

    // The read port is addressed one byte ahead so rd_reg holds byte idx.
    logic [PW-1:0] rd_addr;

    always_ff @(posedge clk)
    begin
        if (buf_we)
            mem[buf_addr] <= buf_data;
        rd_reg <= mem[rd_addr[AW-1:0]];
    end

    assign slot_free = !ov_reg || pop;
    assign cmd_ready = (st_reg == ufur_pkg::BS_IDLE);
    assign empty     = !ov_reg;
    assign result    = ob_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ufur_pkg::BS_IDLE;
            idx_reg  <= '0;
            tail_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            idx_reg  <= idx_next;
            tail_reg <= tail_next;
            if (emit)
                ov_reg <= 1'b1;
            else if (pop)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid)
            cmd_reg <= cmd;
        if (emit)
            ob_reg <= item;
    end

    always_comb
    begin
        st_next   = st_reg;
        idx_next  = idx_reg;
        tail_next = tail_reg;
        rd_addr   = idx_reg;
        case (st_reg)
            ufur_pkg::BS_IDLE:
            begin
                idx_next  = '0;
                tail_next = '0;
                rd_addr   = '0;
                if (cmd_valid)
                    st_next = cmd.prog ? ufur_pkg::BS_PROG : ufur_pkg::BS_TAIL;
            end
            ufur_pkg::BS_PROG:
            begin
                if (adv)
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_addr  = idx_next;
                    if (idx_next >= pkt_len)
                        st_next = (cmd_reg.count == 2'd0) ? ufur_pkg::BS_IDLE :
                                  ufur_pkg::BS_TAIL;
                end
            end
            ufur_pkg::BS_TAIL:
            begin
                if (adv)
                begin
                    tail_next = tail_reg + 2'd1;
                    if (tail_next >= cmd_reg.count)
                        st_next = ufur_pkg::BS_IDLE;
                end
            end
            default: st_next = ufur_pkg::BS_IDLE;
        endcase
    end

    always_comb
    begin
        item = '0;
        adv  = 1'b0;
        case (st_reg)
            ufur_pkg::BS_PROG:
            begin
                adv = slot_free;
                item.kind       = ufur_pkg::K_PROG;
                item.byte_value = rd_reg;
                item.offset     = base_off + 32'(idx_reg);
                item.last       = (idx_reg + 1'b1 >= pkt_len) && (cmd_reg.count == 2'd0);
            end
            ufur_pkg::BS_TAIL:
            begin
                adv = slot_free;
                case (tail_reg)
                    2'd0:
                    begin
                        item.kind       = cmd_reg.kind0;
                        item.byte_value = cmd_reg.byte0;
                    end
                    2'd1:
                    begin
                        item.kind       = cmd_reg.kind1;
                        item.byte_value = cmd_reg.byte1;
                    end
                    default:
                    begin
                        item.kind       = cmd_reg.kind2;
                        item.image_size = cmd_reg.size2;
                        item.image_crc  = cmd_reg.crc2;
                    end
                endcase
                item.last = (tail_reg + 2'd1 >= cmd_reg.count);
            end
            default: ;
        endcase
        emit = adv;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !pop) |=> $stable(ob_reg)) else $error("held result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ufur_pkg::BS_PROG) |-> idx_reg < pkt_len) else $error("program index overrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ufur_pkg::BS_TAIL) |-> cmd_reg.count != 2'd0) else $error("empty tail");
endmodule

[rtl/core/uart_firmware_update_receiver.sv]
// Results: an item's results pass through the command register and back-part state,
// then the output register, before the result ports; a verified packet streams one
// program byte per cycle while the held result is popped or the output is empty.
// Flow control: an item with no results leaves full low; an item with results holds
// full high until all of them are emitted, which waits while a held result is not popped.
// Reset (rst_n, asynchronous, active low) restores register defaults and the
// magic-hunting phase; the packet buffer is not cleared.
module uart_firmware_update_receiver #(
    parameter int PAYLOAD_MAX = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  ufur_pkg::in_item_t   in_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    output logic                 empty,
    input  logic                 pop,
    output ufur_pkg::out_item_t  result
);
    localparam int PW = $clog2(PAYLOAD_MAX + 1);
    localparam int AW = $clog2(PAYLOAD_MAX);

    logic cmd_valid, cmd_ready, buf_we;
    ufur_pkg::cmd_t cmd;
    logic [AW-1:0] buf_addr;
    logic [7:0] buf_data, ack_code;
    logic [PW-1:0] pkt_len;
    logic [31:0] base_off;

    assign cfg_ready = 1'b1;

    ufur_front #(.PAYLOAD_MAX(PAYLOAD_MAX), .PW(PW), .AW(AW)) u_front (
        .clk, .rst_n, .push, .full, .in_item,
        .cfg_valid, .cfg_index, .cfg_data, .ack_code,
        .cmd_valid, .cmd_ready, .cmd,
        .buf_we, .buf_addr, .buf_data, .pkt_len, .base_off
    );

    ufur_back #(.PAYLOAD_MAX(PAYLOAD_MAX), .PW(PW), .AW(AW)) u_back (
        .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
        .buf_we, .buf_addr, .buf_data, .pkt_len, .base_off,
        .empty, .pop, .result
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |-> cmd_ready) else $error("item taken while back part busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ack_code == ack_code) || cfg_valid) else $error("ack code unknown");
endmodule

[dv/ufur_checker.sv]
module ufur_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  ufur_pkg::in_item_t  in_item,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                empty,
    input  logic                pop,
    input  ufur_pkg::out_item_t result,
    output int                  fail_count,
    output int                  pending,
    output int                  results_seen,
    output ufur_pkg::phase_t    phase_now
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAYLOAD = 32;

    // Register copies
    logic [63:0] magic_w;
    logic [3:0]  magic_span;
    logic [31:0] window_len;
    logic [31:0] capacity;
    logic [7:0]  retry_limit;
    logic [7:0]  ack_byte;
    logic [7:0]  nak_byte;

    // Transfer state
    ufur_pkg::phase_t ph;
    logic [3:0]  matched;
    logic [31:0] ticks_in_window;
    logic [11:0] quiet_ms;
    logic [31:0] shreg;
    logic [3:0]  field_bytes;
    logic [31:0] img_len;
    logic [31:0] img_crc_wanted;
    logic [31:0] accepted;
    int          pkt_len;
    int          pkt_got;
    logic [7:0]  attempts;
    logic [31:0] pkt_crc;
    logic [31:0] crc_commit;
    logic [31:0] crc_tent;
    logic [7:0]  pkt_store [PAYLOAD];

    ufur_pkg::out_item_t awaited_results [$];
    int          mismatches;

    function automatic logic [31:0] crc32_step(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        return c;
    endfunction

    task post(logic [2:0] k, logic [7:0] bv, logic [31:0] off, logic [31:0] sz,
              logic [31:0] crc);
        ufur_pkg::out_item_t r;
        r.kind = k;
        r.byte_value = bv;
        r.offset = off;
        r.image_size = sz;
        r.image_crc = crc;
        r.last = 1'b0;
        awaited_results.push_back(r);
    endtask

    task restart_attempt();
        pkt_got = 0;
        quiet_ms = '0;
        pkt_crc = '1;
        crc_tent = crc_commit;
        shreg = '0;
        field_bytes = '0;
        ph = ufur_pkg::PH_PAYLOAD;
    endtask

    task next_packet();
        logic [31:0] rem;
        rem = img_len - accepted;
        pkt_len = (rem > PAYLOAD) ? PAYLOAD : int'(rem);
        attempts = '0;
        restart_attempt();
    endtask

    task give_up(bit with_nak);
        if (with_nak)
            post(ufur_pkg::K_SEND, nak_byte, 0, 0, 0);
        ph = ufur_pkg::PH_END;
        post(ufur_pkg::K_FAIL, 0, 0, 0, 0);
    endtask

    task resend_or_abort();
        logic [7:0] lim;
        lim = (retry_limit == 0) ? 8'd1 : retry_limit;
        post(ufur_pkg::K_SEND, nak_byte, 0, 0, 0);
        attempts = attempts + 8'd1;
        if (attempts >= lim)
            give_up(1'b0);
        else
            restart_attempt();
    endtask

    task take_field_byte(logic [7:0] b);
        shreg = (shreg >> 8) | ({24'd0, b} << 24);
        field_bytes = field_bytes + 4'd1;
        quiet_ms = '0;
    endtask

    task advance_transfer(ufur_pkg::in_item_t it);
        int         n0;
        int         len_eff;
        logic [7:0] want;
        logic [7:0] b;
        ufur_pkg::out_item_t tail;
        n0 = awaited_results.size();
        b = it.rx_byte;
        case (ph)
            ufur_pkg::PH_HUNT:
            begin
                if (it.func == ufur_pkg::FUNC_TICK)
                begin
                    if (ticks_in_window != '1)
                        ticks_in_window++;
                    if (ticks_in_window >= window_len)
                    begin
                        ph = ufur_pkg::PH_END;
                        post(ufur_pkg::K_NOUPD, 0, 0, 0, 0);
                    end
                end
                else if (it.func == ufur_pkg::FUNC_BYTE)
                begin
                    len_eff = (magic_span == 0) ? 1 :
                              ((magic_span > 8) ? 8 : int'(magic_span));
                    want = magic_w[8 * matched[2:0] +: 8];
                    if (ticks_in_window >= window_len)
                    begin
                        ph = ufur_pkg::PH_END;
                        post(ufur_pkg::K_NOUPD, 0, 0, 0, 0);
                    end
                    else if (b == want)
                    begin
                        matched = matched + 4'd1;
                        if (matched >= len_eff)
                        begin
                            post(ufur_pkg::K_SEND, ack_byte, 0, 0, 0);
                            ph = ufur_pkg::PH_HEADER;
                            shreg = '0;
                            field_bytes = '0;
                            quiet_ms = '0;
                        end
                    end
                    else
                    begin
                        matched = (b == magic_w[7:0]) ? 4'd1 : 4'd0;
                    end
                end
            end
            ufur_pkg::PH_HEADER:
            begin
                if (it.func == ufur_pkg::FUNC_TICK)
                begin
                    if (quiet_ms < 12'd4095)
                        quiet_ms++;
                    if (quiet_ms >= ufur_pkg::HEADER_TIMEOUT)
                        give_up(1'b1);
                end
                else if (it.func == ufur_pkg::FUNC_BYTE)
                begin
                    take_field_byte(b);
                    if (field_bytes == 4'd4)
                        img_len = shreg;
                    else if (field_bytes == 4'd8)
                        img_crc_wanted = shreg;
                    else if (field_bytes >= 4'd12)
                    begin
                        field_bytes = '0;
                        if (img_len == 0 || img_len > capacity)
                            give_up(1'b1);
                        else
                        begin
                            post(ufur_pkg::K_SEND, ack_byte, 0, 0, 0);
                            post(ufur_pkg::K_ERASE, 0, 0, 0, 0);
                            ph = ufur_pkg::PH_ERASE;
                        end
                    end
                end
            end
            ufur_pkg::PH_ERASE:
            begin
                if (it.func == ufur_pkg::FUNC_FLASH)
                begin
                    if (!it.flash_ok)
                        give_up(1'b1);
                    else
                    begin
                        accepted = '0;
                        crc_commit = '1;
                        next_packet();
                    end
                end
            end
            ufur_pkg::PH_PAYLOAD, ufur_pkg::PH_PKTCRC:
            begin
                if (it.func == ufur_pkg::FUNC_TICK)
                begin
                    if (quiet_ms < 12'd4095)
                        quiet_ms++;
                    if (quiet_ms >= ufur_pkg::PACKET_TIMEOUT)
                        resend_or_abort();
                end
                else if (it.func == ufur_pkg::FUNC_BYTE && ph == ufur_pkg::PH_PAYLOAD)
                begin
                    quiet_ms = '0;
                    if (pkt_got < pkt_len && pkt_got < PAYLOAD)
                    begin
                        pkt_store[pkt_got] = b;
                        pkt_crc = crc32_step(pkt_crc, b);
                        crc_tent = crc32_step(crc_tent, b);
                        pkt_got++;
                    end
                    if (pkt_got >= pkt_len)
                    begin
                        ph = ufur_pkg::PH_PKTCRC;
                        shreg = '0;
                        field_bytes = '0;
                    end
                end
                else if (it.func == ufur_pkg::FUNC_BYTE)
                begin
                    take_field_byte(b);
                    if (field_bytes >= 4'd4)
                    begin
                        field_bytes = '0;
                        if (~pkt_crc == shreg)
                        begin
                            for (int i = 0; i < pkt_len && i < PAYLOAD; i++)
                                post(ufur_pkg::K_PROG, pkt_store[i], accepted + i, 0, 0);
                            ph = ufur_pkg::PH_PROGRAM;
                        end
                        else
                            resend_or_abort();
                    end
                end
            end
            ufur_pkg::PH_PROGRAM:
            begin
                if (it.func == ufur_pkg::FUNC_FLASH)
                begin
                    if (!it.flash_ok)
                        give_up(1'b1);
                    else
                    begin
                        post(ufur_pkg::K_SEND, ack_byte, 0, 0, 0);
                        crc_commit = crc_tent;
                        accepted = accepted + pkt_len;
                        if (accepted >= img_len)
                        begin
                            if (~crc_commit != img_crc_wanted)
                                give_up(1'b1);
                            else
                            begin
                                post(ufur_pkg::K_SEND, ack_byte, 0, 0, 0);
                                post(ufur_pkg::K_DONE, 0, 0, img_len, ~crc_commit);
                                ph = ufur_pkg::PH_END;
                            end
                        end
                        else
                            next_packet();
                    end
                end
            end
            default:
            begin
            end
        endcase
        // The final result caused by this item carries the last flag.
        if (awaited_results.size() > n0)
        begin
            tail = awaited_results.pop_back();
            tail.last = 1'b1;
            awaited_results.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ufur_pkg::out_item_t exp_r;
        if (!rst_n)
        begin
            magic_w = '0;
            magic_span = 4'd8;
            window_len = 32'd5000;
            capacity = 32'd131072;
            retry_limit = 8'd3;
            ack_byte = 8'd6;
            nak_byte = 8'd21;
            ph = ufur_pkg::PH_HUNT;
            matched = '0;
            ticks_in_window = '0;
            quiet_ms = '0;
            shreg = '0;
            field_bytes = '0;
            img_len = '0;
            img_crc_wanted = '0;
            accepted = '0;
            pkt_len = 0;
            pkt_got = 0;
            attempts = '0;
            pkt_crc = '1;
            crc_commit = '1;
            crc_tent = '1;
            awaited_results.delete();
            fail_count = 0;
            mismatches = 0;
            results_seen = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                results_seen++;
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: kind %0d byte %h", result.kind,
                                 result.byte_value);
                end
                else
                begin
                    exp_r = awaited_results.pop_front();
                    if (result !== exp_r)
                    begin
                        fail_count++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: expected kind %0d byte %h off %h ",
                                      "size %h crc %h last %b, got kind %0d byte %h ",
                                      "off %h size %h crc %h last %b"},
                                     exp_r.kind, exp_r.byte_value, exp_r.offset,
                                     exp_r.image_size, exp_r.image_crc, exp_r.last,
                                     result.kind, result.byte_value, result.offset,
                                     result.image_size, result.image_crc, result.last);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ufur_pkg::REG_MAGIC_WORD:    magic_w = cfg_data;
                    ufur_pkg::REG_MAGIC_LENGTH:  magic_span = cfg_data[3:0];
                    ufur_pkg::REG_WINDOW_MS:     window_len = cfg_data[31:0];
                    ufur_pkg::REG_SLOT_CAPACITY: capacity = cfg_data[31:0];
                    ufur_pkg::REG_MAX_RETRIES:   retry_limit = cfg_data[7:0];
                    ufur_pkg::REG_ACK_CODE:      ack_byte = cfg_data[7:0];
                    ufur_pkg::REG_NAK_CODE:      nak_byte = cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (push && !full)
                advance_transfer(in_item);
        end
        pending = awaited_results.size();
        phase_now = ph;
    end

endmodule

[dv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 60000;
    localparam int SETTLE_CYCLES = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    ufur_pkg::in_item_t  in_item = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        empty;
    logic        pop = 1'b0;
    ufur_pkg::out_item_t result;

    int          fails;
    int          pending;
    int          results_seen;
    ufur_pkg::phase_t chk_phase;

    int          cycles = 0;
    bit          quiet = 1'b0;
    int          items_sent = 0;
    int          resends = 0;
    int          packets = 0;
    int          retry_cap = 3;

    logic [63:0] magic;
    int          magic_n;
    int          img_n;
    logic [7:0]  image [256];
    logic [31:0] img_crc;

    uart_firmware_update_receiver DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .empty(empty), .pop(pop), .result(result)
    );

    ufur_checker CHK (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .empty(empty), .pop(pop), .result(result),
        .fail_count(fails), .pending(pending), .results_seen(results_seen),
        .phase_now(chk_phase)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        pop <= quiet || ($urandom_range(99) >= 26);

    function automatic logic [31:0] crc_next(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        return c;
    endfunction

    // Leaves push high so that back-to-back items need no gap.
    task automatic send(logic [1:0] f, logic [7:0] b, logic ok);
        ufur_pkg::in_item_t it;
        while (!quiet && $urandom_range(99) < 26)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        it.func = f;
        it.rx_byte = b;
        it.flash_ok = ok;
        push <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic settle();
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        if (idx == ufur_pkg::REG_MAX_RETRIES)
            retry_cap = (d[7:0] == 0) ? 1 : int'(d[7:0]);
    endtask

    // Random tick, flash, reserved or (if bytes_too) byte items as noise.
    task automatic noise(bit bytes_too);
        int k;
        k = $urandom_range(3);
        if ($urandom_range(99) < 70)
            k = 0;
        repeat (k)
        begin
            case ($urandom_range(bytes_too ? 3 : 2))
                0: send(ufur_pkg::FUNC_TICK, 8'($urandom), 1'($urandom));
                1: send(ufur_pkg::FUNC_FLASH, 8'($urandom), 1'($urandom));
                2: send(ufur_pkg::FUNC_RESERVED, 8'($urandom), 1'($urandom));
                default: send(ufur_pkg::FUNC_BYTE, 8'($urandom), 1'($urandom));
            endcase
        end
    endtask

    task automatic send_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
        begin
            noise(1'b0);
            send(ufur_pkg::FUNC_BYTE, w[8 * i +: 8], 1'($urandom));
        end
    endtask

    initial
    begin
        int off;
        int len;
        int tries;
        logic [31:0] pcrc;
        bit delivered;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default registers: a few items that cannot end the hunt.
        send(ufur_pkg::FUNC_TICK, 8'h00, 1'b0);
        send(ufur_pkg::FUNC_FLASH, 8'hFF, 1'b1);
        send(ufur_pkg::FUNC_RESERVED, 8'hFF, 1'b1);
        send(ufur_pkg::FUNC_TICK, 8'hFF, 1'b1);
        settle();

        magic = {$urandom, $urandom};
        write_reg(ufur_pkg::REG_MAGIC_WORD, magic);
        write_reg(ufur_pkg::REG_SLOT_CAPACITY, 64'd0);
        write_reg(ufur_pkg::REG_SLOT_CAPACITY, 64'hFFFF_FFFF);
        write_reg(ufur_pkg::REG_MAGIC_LENGTH, 64'd1);
        write_reg(ufur_pkg::REG_MAGIC_LENGTH, 64'd8);
        write_reg(ufur_pkg::REG_WINDOW_MS, 64'hFFFF_FFFF);
        write_reg(ufur_pkg::REG_MAX_RETRIES, 64'd255);
        write_reg(ufur_pkg::REG_ACK_CODE, 64'd0);
        write_reg(ufur_pkg::REG_NAK_CODE, 64'd255);

        // Hunt noise with a random magic string of full length.
        send(ufur_pkg::FUNC_BYTE, 8'h00, 1'b0);
        send(ufur_pkg::FUNC_BYTE, 8'hFF, 1'b1);
        send(ufur_pkg::FUNC_BYTE, magic[7:0], 1'b0);
        send(ufur_pkg::FUNC_BYTE, magic[15:8], 1'b1);
        send(ufur_pkg::FUNC_BYTE, 8'h5A, 1'b0);
        send(ufur_pkg::FUNC_FLASH, 8'h00, 1'b0);
        repeat (14)
            send(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
        settle();

        img_n = $urandom_range(66, 84);
        img_crc = '1;
        for (int i = 0; i < img_n; i++)
        begin
            image[i] = 8'($urandom);
            img_crc = crc_next(img_crc, image[i]);
        end
        img_crc = ~img_crc;

        magic_n = $urandom_range(1, 8);
        write_reg(ufur_pkg::REG_MAGIC_LENGTH, 64'(magic_n));
        write_reg(ufur_pkg::REG_SLOT_CAPACITY, 64'(img_n));
        write_reg(ufur_pkg::REG_WINDOW_MS, {32'd0, $urandom | 32'h8000_0000});
        write_reg(ufur_pkg::REG_ACK_CODE, 64'($urandom_range(255)));
        write_reg(ufur_pkg::REG_NAK_CODE, 64'($urandom_range(255)));

        tries = 0;
        while (chk_phase == ufur_pkg::PH_HUNT && tries < 40)
        begin
            send(ufur_pkg::FUNC_BYTE, magic[8 * (tries % magic_n) +: 8], 1'($urandom));
            tries++;
        end

        // Header: size, image CRC and a reserved word.
        send_word(32'(img_n));
        send_word(img_crc);
        send_word($urandom);

        noise(1'b1);
        send(ufur_pkg::FUNC_BYTE, 8'($urandom), 1'b0);
        send(ufur_pkg::FUNC_TICK, 8'($urandom), 1'b0);
        send(ufur_pkg::FUNC_FLASH, 8'($urandom), 1'b1);

        off = 0;
        while (off < img_n)
        begin
            len = (img_n - off > 32) ? 32 : img_n - off;
            quiet = (packets == 2);
            pcrc = '1;
            for (int i = 0; i < len; i++)
                pcrc = crc_next(pcrc, image[off + i]);
            pcrc = ~pcrc;
            tries = 0;
            delivered = 1'b0;
            while (!delivered)
            begin
                for (int i = 0; i < len; i++)
                begin
                    noise(1'b0);
                    send(ufur_pkg::FUNC_BYTE, image[off + i], 1'($urandom));
                end
                if (tries + 1 < retry_cap && $urandom_range(99) < 20)
                begin
                    send_word(pcrc ^ (32'd1 << $urandom_range(31)));
                    tries++;
                    resends++;
                end
                else
                begin
                    send_word(pcrc);
                    delivered = 1'b1;
                end
            end
            noise(1'b1);
            send(ufur_pkg::FUNC_FLASH, 8'($urandom), 1'b1);
            off += len;
            packets++;
            if (packets == 1)
            begin
                settle();
                write_reg(ufur_pkg::REG_ACK_CODE, 64'd255);
                write_reg(ufur_pkg::REG_NAK_CODE, 64'd0);
            end
            else if (packets == 3)
            begin
                settle();
                write_reg(ufur_pkg::REG_MAX_RETRIES, 64'($urandom_range(2, 254)));
                write_reg(ufur_pkg::REG_ACK_CODE, 64'($urandom_range(255)));
                write_reg(ufur_pkg::REG_NAK_CODE, 64'($urandom_range(255)));
            end
            if (off < img_n && img_n - off <= 32)
            begin
                settle();
                write_reg(ufur_pkg::REG_MAX_RETRIES, 64'd1);
            end
        end
        quiet = 1'b0;

        // Everything after completion is ignored.
        repeat (6)
            send(2'($urandom_range(3)), 8'($urandom), 1'($urandom));

        settle();
        $display("Transfer of %0d bytes in %0d packets with %0d resends after a %0d-byte magic.",
                 img_n, packets, resends, magic_n);
        $display("%0d items sent, %0d result items checked.", items_sent, results_seen);
        if (fails == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
